// File: src/vsa_pkg.sv
`timescale 1ns / 1ps

package vsa_pkg;

  // Default number of variables held in the activity and assignment memories.
  localparam int NumVarsDefault = 1024;

  // Fixed field widths of the item and result ports.
  localparam int VarIdxW   = 11;
  localparam int ScoreW    = 32;
  localparam int DecayW    = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  // Configuration register indexes and reset values.
  localparam logic [CfgIdxW-1:0] CFG_BUMP_AMOUNT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_FACTOR = 2'd1;
  localparam logic [ScoreW-1:0]  BumpAmountReset  = 32'd65536;
  localparam logic [DecayW-1:0]  DecayFactorReset = 16'd62259;

  // Command codes of an input request.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_BUMP   = 2'd1,
    CMD_SET    = 2'd2,
    CMD_CHOOSE = 2'd3
  } cmd_e;

  // One input request as seen by the engine.
  typedef struct packed {
    cmd_e               cmd;
    logic [VarIdxW-1:0] variable_index;
    logic               end_of_clause;
    logic               assigned_value;
  } item_t;

  // Current configuration register contents.
  typedef struct packed {
    logic [ScoreW-1:0] bump_amount;
    logic [DecayW-1:0] decay_factor;
  } cfg_t;

  // Result of a choose request.
  typedef struct packed {
    logic [VarIdxW-1:0] chosen_variable;
    logic               none_free;
  } res_t;

endpackage

// File: src/vsids_activity_scan.sv
`timescale 1ns / 1ps
// Clear sweeps the activity memory, set writes the assigned mark, bump reads the
// score and writes it back, then decays all scores if end of clause is set, and
// choose scans both memories. Throughput: one request at a time; clear, decay and
// choose each sweep the activity memory at one entry per cycle.
// Reset: after rst_ni is released a clearing pass zeroes both memories while
// in_ready_o is low; configuration writes are taken.

module vsids_activity_scan
  import vsa_pkg::*;
#(
  parameter int NUM_VARS = NumVarsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [VarIdxW-1:0]  variable_index_i,
  input  logic                end_of_clause_i,
  input  logic                assigned_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VarIdxW-1:0]  chosen_variable_o,
  output logic                none_free_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  logic  res_valid;
  logic  res_ready;
  logic  out_valid_q;
  res_t  out_q;

  // Configuration registers; an index beyond the list is ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bump_amount  <= BumpAmountReset;
      cfg_q.decay_factor <= DecayFactorReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BUMP_AMOUNT) begin
        cfg_q.bump_amount <= cfg_data_i;
      end else if (cfg_index_i == CFG_DECAY_FACTOR) begin
        cfg_q.decay_factor <= cfg_data_i[DecayW-1:0];
      end
    end
  end

  // Input request bundle.
  assign item.cmd            = cmd_e'(cmd_i);
  assign item.variable_index = variable_index_i;
  assign item.end_of_clause  = end_of_clause_i;
  assign item.assigned_value = assigned_value_i;

  // Output register: a finished result waits here while new requests enter.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chosen_variable_o = out_q.chosen_variable;
  assign none_free_o       = out_q.none_free;

  vsa_engine #(
    .NUM_VARS(NUM_VARS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .item_valid_i(in_valid_i),
    .item_ready_o(in_ready_o),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

endmodule

// File: src/vsa_ram.sv
`timescale 1ns / 1ps

module vsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/vsa_engine.sv
`timescale 1ns / 1ps

module vsa_engine
  import vsa_pkg::*;
#(
  parameter int NUM_VARS = NumVarsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  output res_t  res_o,
  output logic  res_valid_o,
  input  logic  res_ready_i
);

  localparam int AW = $clog2(NUM_VARS);
  localparam int CW = $clog2(NUM_VARS + 1);
  localparam int PW = ScoreW + DecayW;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_BUMP_WR,
    S_DECAY,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic [AW-1:0]     addr_q;
  logic              eoc_q;
  logic              s1_q;
  logic [AW-1:0]     s1_addr_q;
  logic              s2_q;
  logic [AW-1:0]     s2_addr_q;
  logic [PW-1:0]     prod_q;
  logic [ScoreW-1:0] best_q;
  logic [CW-1:0]     chosen_q;
  logic              found_q;

  logic              act_we, act_re;
  logic [AW-1:0]     act_waddr, act_raddr;
  logic [ScoreW-1:0] act_wdata, act_rdata;
  logic              asg_we, asg_re;
  logic [AW-1:0]     asg_waddr;
  logic [0:0]        asg_wdata, asg_rdata;

  logic              accept;
  logic [31:0]       v_ext;
  logic [31:0]       v_m1;
  logic              v_ok;
  logic [AW-1:0]     in_addr;
  logic              not_done;
  logic              sweep_last;
  logic [ScoreW:0]   bump_sum;
  logic [ScoreW-1:0] bump_sat;
  logic [31:0]       chosen_ext;

  // Request decoding and range check of the variable number.
  assign item_ready_o = (state_q == S_IDLE);
  assign accept       = item_valid_i && item_ready_o;
  assign v_ext        = 32'(item_i.variable_index);
  assign v_m1         = v_ext - 32'd1;
  assign v_ok         = (v_ext != 32'd0) && (v_ext <= 32'(NUM_VARS));
  assign in_addr      = v_m1[AW-1:0];

  assign not_done   = (cnt_q != CW'(NUM_VARS));
  assign sweep_last = (cnt_q == CW'(NUM_VARS - 1));

  // Saturating bump of the score read back from memory.
  assign bump_sum = {1'b0, act_rdata} + {1'b0, cfg_i.bump_amount};
  assign bump_sat = bump_sum[ScoreW] ? {ScoreW{1'b1}} : bump_sum[ScoreW-1:0];

  // Memory port control for each sequencer state.
  always_comb begin
    act_re    = 1'b0;
    act_raddr = cnt_q[AW-1:0];
    act_we    = 1'b0;
    act_waddr = cnt_q[AW-1:0];
    act_wdata = '0;
    asg_re    = 1'b0;
    asg_we    = 1'b0;
    asg_waddr = cnt_q[AW-1:0];
    asg_wdata = 1'b0;
    case (state_q)
      S_INIT: begin
        act_we = 1'b1;
        asg_we = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            CMD_BUMP: begin
              act_re    = v_ok;
              act_raddr = in_addr;
            end
            CMD_SET: begin
              asg_we    = v_ok;
              asg_waddr = in_addr;
              asg_wdata = item_i.assigned_value;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        act_we = 1'b1;
      end
      S_BUMP_WR: begin
        act_we    = 1'b1;
        act_waddr = addr_q;
        act_wdata = bump_sat;
      end
      S_DECAY: begin
        act_re    = not_done;
        act_we    = s2_q;
        act_waddr = s2_addr_q;
        act_wdata = prod_q[PW-1:DecayW];
      end
      S_SCAN: begin
        act_re = not_done;
        asg_re = not_done;
      end
      default: ;
    endcase
  end

  // Sequencer state, sweep counter and the scan and decay pipelines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      cnt_q     <= '0;
      addr_q    <= '0;
      eoc_q     <= 1'b0;
      s1_q      <= 1'b0;
      s1_addr_q <= '0;
      s2_q      <= 1'b0;
      s2_addr_q <= '0;
      prod_q    <= '0;
      best_q    <= '0;
      chosen_q  <= '0;
      found_q   <= 1'b0;
    end else begin
      case (state_q)
        S_INIT, S_CLEAR: begin
          cnt_q <= cnt_q + CW'(1);
          if (sweep_last) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            case (item_i.cmd)
              CMD_CLEAR: begin
                state_q <= S_CLEAR;
              end
              CMD_BUMP: begin
                eoc_q  <= item_i.end_of_clause;
                addr_q <= in_addr;
                if (v_ok) begin
                  state_q <= S_BUMP_WR;
                end else if (item_i.end_of_clause) begin
                  state_q <= S_DECAY;
                end
              end
              CMD_CHOOSE: begin
                found_q  <= 1'b0;
                best_q   <= '0;
                chosen_q <= '0;
                state_q  <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_BUMP_WR: begin
          state_q <= eoc_q ? S_DECAY : S_IDLE;
        end
        S_DECAY: begin
          s1_q      <= not_done;
          s1_addr_q <= cnt_q[AW-1:0];
          if (not_done) begin
            cnt_q <= cnt_q + CW'(1);
          end
          s2_q      <= s1_q;
          s2_addr_q <= s1_addr_q;
          prod_q    <= PW'(act_rdata) * PW'(cfg_i.decay_factor);
          if (!not_done && !s1_q && !s2_q) begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          s1_q      <= not_done;
          s1_addr_q <= cnt_q[AW-1:0];
          if (not_done) begin
            cnt_q <= cnt_q + CW'(1);
          end
          // A later free variable with an equal score takes over.
          if (s1_q && !asg_rdata[0] && (!found_q || act_rdata >= best_q)) begin
            best_q   <= act_rdata;
            chosen_q <= CW'(s1_addr_q) + CW'(1);
            found_q  <= 1'b1;
          end
          if (!not_done && !s1_q) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result of a finished scan.
  assign chosen_ext            = 32'(chosen_q);
  assign res_valid_o           = (state_q == S_RESULT);
  assign res_o.chosen_variable = chosen_ext[VarIdxW-1:0];
  assign res_o.none_free       = !found_q;

  vsa_ram #(
    .WIDTH(ScoreW),
    .DEPTH(NUM_VARS)
  ) u_act_ram (
    .clk_i  (clk_i),
    .we_i   (act_we),
    .waddr_i(act_waddr),
    .wdata_i(act_wdata),
    .re_i   (act_re),
    .raddr_i(act_raddr),
    .rdata_o(act_rdata)
  );

  vsa_ram #(
    .WIDTH(1),
    .DEPTH(NUM_VARS)
  ) u_asg_ram (
    .clk_i  (clk_i),
    .we_i   (asg_we),
    .waddr_i(asg_waddr),
    .wdata_i(asg_wdata),
    .re_i   (asg_re),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(asg_rdata)
  );

  // The decay pass never reads the entry it writes in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_we && act_re) |-> (act_waddr != act_raddr))
    else $error("activity memory read and write collide");

  // The scan and decay pipelines are drained whenever a request can enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_ready_o |-> (!s1_q && !s2_q))
    else $error("pipeline not empty in idle");

  // A result handed over returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> item_ready_o)
    else $error("sequencer did not return to idle after result");

  // A found variable has a nonzero number, and none found means zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (found_q == (chosen_q != '0)))
    else $error("chosen variable and found flag disagree");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vsa_pkg::*;

  localparam int VarCount      = NumVarsDefault;
  // A clear, decay or choose sweep steps through all VarCount entries.
  localparam int SettleCycles  = VarCount + 64;
  localparam int WatchdogLimit = 20000;
  localparam int ReportLimit   = 10;
  localparam int PhaseRequests = 110;
  localparam int MaxVarIndex   = (1 << VarIdxW) - 1;

  // Register indexes that the block decodes to nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          cmd_i;
  logic [VarIdxW-1:0]  variable_index_i;
  logic                end_of_clause_i;
  logic                assigned_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [VarIdxW-1:0]  chosen_variable_o;
  logic                none_free_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Mirror of the activity scores, assigned marks and registers.
  logic [ScoreW-1:0] score_mirror [VarCount];
  bit                taken_mirror [VarCount];
  logic [ScoreW-1:0] bump_step;
  logic [DecayW-1:0] decay_mult;
  res_t              pending_choices [$];

  int fail_count;
  int idle_cycles;
  int stall_left;
  bit tx_calm;
  bit rx_calm;

  vsids_activity_scan #(
    .NUM_VARS(VarCount)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .variable_index_i (variable_index_i),
    .end_of_clause_i  (end_of_clause_i),
    .assigned_value_i (assigned_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .chosen_variable_o(chosen_variable_o),
    .none_free_o      (none_free_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic void reset_mirror();
    int i;
    bump_step  = BumpAmountReset;
    decay_mult = DecayFactorReset;
    for (i = 0; i < VarCount; i++) begin
      score_mirror[i] = '0;
      taken_mirror[i] = 1'b0;
    end
  endfunction

  // Scale every score by the Q0.16 decay factor, truncating.
  function automatic void decay_scores();
    int i;
    logic [ScoreW+DecayW-1:0] prod;
    for (i = 0; i < VarCount; i++) begin
      prod = {{DecayW{1'b0}}, score_mirror[i]} * {{ScoreW{1'b0}}, decay_mult};
      score_mirror[i] = prod[ScoreW+DecayW-1:DecayW];
    end
  endfunction

  // Highest score among free variables; the later index wins a tie.
  function automatic res_t best_free_variable();
    int i;
    bit found;
    logic [ScoreW-1:0] best;
    res_t pick;
    found = 1'b0;
    best  = '0;
    pick  = '0;
    for (i = 0; i < VarCount; i++) begin
      if (!taken_mirror[i] && (!found || score_mirror[i] >= best)) begin
        best                 = score_mirror[i];
        pick.chosen_variable = VarIdxW'(i + 1);
        found                = 1'b1;
      end
    end
    pick.none_free = !found;
    return pick;
  endfunction

  function automatic void apply_request(cmd_e cmd, logic [VarIdxW-1:0] idx, logic eoc,
                                        logic av);
    int i;
    bit in_range;
    logic [ScoreW:0] sum;
    in_range = (idx >= 1) && (idx <= VarCount);
    case (cmd)
      CMD_CLEAR: begin
        for (i = 0; i < VarCount; i++) score_mirror[i] = '0;
      end
      CMD_BUMP: begin
        if (in_range) begin
          sum = {1'b0, score_mirror[idx-1]} + {1'b0, bump_step};
          score_mirror[idx-1] = sum[ScoreW] ? {ScoreW{1'b1}} : sum[ScoreW-1:0];
        end
        if (eoc) decay_scores();
      end
      CMD_SET: begin
        if (in_range) taken_mirror[idx-1] = av;
      end
      CMD_CHOOSE: begin
        pending_choices.insert(pending_choices.size(), best_free_variable());
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == CFG_BUMP_AMOUNT) begin
      bump_step = data[ScoreW-1:0];
    end else if (idx == CFG_DECAY_FACTOR) begin
      decay_mult = data[DecayW-1:0];
    end
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long pause.
  function automatic int idle_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Most traffic goes to a few hot variables at both ends of the table.
  function automatic int pick_variable();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(1, 8);
    if (r < 70) return $urandom_range(VarCount - 7, VarCount);
    if (r < 92) return $urandom_range(1, VarCount);
    if (r < 96) return 0;
    return $urandom_range(VarCount + 1, MaxVarIndex);
  endfunction

  // Update the mirror on every accepted request and register write.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      apply_request(cmd_e'(cmd_i), variable_index_i, end_of_clause_i, assigned_value_i);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      apply_config(cfg_index_i, cfg_data_i);
    end
  end

  // Compare each accepted choose result with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_choices.size() == 0) begin
        note_failure($sformatf("unexpected result: var %0d none_free %0b",
                               chosen_variable_o, none_free_o));
      end else begin
        want = pending_choices.pop_front();
        if (want.chosen_variable !== chosen_variable_o || want.none_free !== none_free_o) begin
          note_failure($sformatf("choose mismatch: expected var %0d none_free %0b, got var %0d none_free %0b",
                                 want.chosen_variable, want.none_free,
                                 chosen_variable_o, none_free_o));
        end
      end
    end
  end

  // Result side: ready, then a random stall that may be empty.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = idle_gap(rx_calm);
    end
  end

  // End the run if no request moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one request and hold it until accepted. Valid stays high on return
  // so that a following request can go out back to back.
  task automatic send_request(cmd_e cmd, int idx, bit eoc, bit av);
    int gap;
    gap = idle_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    variable_index_i <= VarIdxW'(idx);
    end_of_clause_i  <= eoc;
    assigned_value_i <= av;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_choices.size() != 0) @(posedge clk_i);
  endtask

  // Bring the block to idle: no request in flight and no sweep running.
  task automatic quiesce();
    release_input();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // All scores are zero and all variables free, so the last one wins.
  task automatic test_reset_state();
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
  endtask

  task automatic test_basic_commands();
    send_request(CMD_BUMP, 1, 1'b0, 1'b1);
    send_request(CMD_CHOOSE, 1, 1'b1, 1'b1);
    send_request(CMD_BUMP, VarCount, 1'b0, 1'b0);
    send_request(CMD_BUMP, VarCount, 1'b0, 1'b0);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
    send_request(CMD_SET, VarCount, 1'b1, 1'b1);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
    send_request(CMD_SET, 1, 1'b0, 1'b1);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
    // Out-of-range indexes touch nothing, but the decay still runs.
    send_request(CMD_BUMP, 0, 1'b1, 1'b0);
    send_request(CMD_BUMP, MaxVarIndex, 1'b0, 1'b1);
    send_request(CMD_SET, 0, 1'b0, 1'b1);
    send_request(CMD_SET, MaxVarIndex, 1'b1, 1'b1);
    send_request(CMD_SET, VarCount + 1, 1'b0, 1'b1);
    send_request(CMD_CHOOSE, MaxVarIndex, 1'b1, 1'b1);
    // Clear zeroes the scores but keeps the assigned marks.
    send_request(CMD_CLEAR, MaxVarIndex, 1'b1, 1'b1);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
    send_request(CMD_SET, 1, 1'b0, 1'b0);
    send_request(CMD_SET, VarCount, 1'b1, 1'b0);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    quiesce();
    write_register(CFG_BUMP_AMOUNT, 32'hFFFF_FFFF);
    write_register(CFG_DECAY_FACTOR, 32'hFFFF_FFFF);
    write_register(CfgSpareLo, $urandom());
    write_register(CfgSpareHi, $urandom());
    // Two maximum bumps saturate, then the slowest decay is applied.
    send_request(CMD_BUMP, 3, 1'b0, 1'b0);
    send_request(CMD_BUMP, 3, 1'b0, 1'b0);
    send_request(CMD_BUMP, 2, 1'b1, 1'b0);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
    quiesce();
    write_register(CFG_BUMP_AMOUNT, 32'h0000_0000);
    write_register(CFG_DECAY_FACTOR, 32'h0000_0000);
    send_request(CMD_BUMP, 5, 1'b1, 1'b1);
    send_request(CMD_CHOOSE, 0, 1'b0, 1'b0);
  endtask

  task automatic run_random_phase(int count, bit calm);
    int i;
    int r;
    int idx;
    tx_calm = calm;
    rx_calm = calm;
    for (i = 0; i < count; i++) begin
      // Now and then hold off until all choose results are back.
      if (!calm && $urandom_range(0, 99) < 3) begin
        release_input();
        wait_drained();
      end
      r   = $urandom_range(0, 99);
      idx = pick_variable();
      if (r < 3) begin
        send_request(CMD_CLEAR, idx, $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (r < 50) begin
        send_request(CMD_BUMP, idx, $urandom_range(0, 99) < 6, $urandom_range(0, 1));
      end else if (r < 80) begin
        send_request(CMD_SET, idx, $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        send_request(CMD_CHOOSE, idx, $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    quiesce();
    write_register(CFG_BUMP_AMOUNT, $urandom_range(1, 32'h0004_0000));
    write_register(CFG_DECAY_FACTOR, $urandom_range(40000, 65535));
    run_random_phase(PhaseRequests, 1'b1);

    quiesce();
    write_register(CFG_BUMP_AMOUNT, $urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
    write_register(CFG_DECAY_FACTOR, 32'h0000_FFFF);
    run_random_phase(PhaseRequests, 1'b0);

    quiesce();
    write_register(CFG_BUMP_AMOUNT, 32'h0000_0000);
    write_register(CFG_DECAY_FACTOR, 32'h0000_0000);
    run_random_phase(PhaseRequests, 1'b0);

    quiesce();
    write_register(CFG_BUMP_AMOUNT, $urandom());
    write_register(CFG_DECAY_FACTOR, $urandom());
    write_register(CfgSpareHi, $urandom());
    run_random_phase(PhaseRequests, 1'b0);

    quiesce();
    write_register(CFG_BUMP_AMOUNT, $urandom_range(1, 16));
    write_register(CFG_DECAY_FACTOR, $urandom_range(0, 65535));
    run_random_phase(PhaseRequests, 1'b0);
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = CMD_CLEAR;
    variable_index_i = '0;
    end_of_clause_i  = 1'b0;
    assigned_value_i = 1'b0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_BUMP_AMOUNT;
    cfg_data_i       = '0;
    tx_calm          = 1'b0;
    rx_calm          = 1'b0;
    fail_count       = 0;
    idle_cycles      = 0;
    stall_left       = 0;
    reset_mirror();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_basic_commands();
    test_register_extremes();
    test_random_traffic();

    // Drain, then allow time for any stray result to show up.
    quiesce();
    if (pending_choices.size() != 0) begin
      note_failure($sformatf("%0d choose results never arrived", pending_choices.size()));
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: vsids_activity_scan.f
src/vsa_pkg.sv
src/vsa_ram.sv
src/vsa_engine.sv
src/vsids_activity_scan.sv
verif/testbench.sv
